@@ sv/prc_pkg.sv @@
// Shared constants for the rotation stream cipher.
`default_nettype none
package prc_pkg;

  localparam int unsigned SEED_W     = 17;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned AMOUNT_W   = 7;

  localparam logic [SEED_W-1:0] GEN_RESET = 17'd1;
  localparam logic [SEED_W-1:0] GEN_MOD   = 17'd65537;
  localparam logic [7:0]        GEN_MULT  = 8'd75;

  localparam logic [BYTE_W-1:0] CODE_LOW  = 8'd32;
  localparam logic [BYTE_W-1:0] CODE_SPAN = 8'd96;

  // x / 3 == (x * DIV3_RECIP) >> DIV3_SHIFT for every 12-bit x
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_START_SEED   = 2'd1
  } reg_idx_t;

endpackage
`default_nettype wire

@@ sv/prc_ifs.sv @@
// Channel interfaces: byte input, byte output and configuration writes.
`default_nettype none
interface prc_in_if;
  logic                      valid;
  logic                      ready;
  logic [prc_pkg::BYTE_W-1:0] data_byte;
  logic                      restart;
  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface prc_out_if;
  logic                      valid;
  logic                      ready;
  logic [prc_pkg::BYTE_W-1:0] out_byte;
  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface prc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [prc_pkg::CFG_IDX_W-1:0] index;
  logic [prc_pkg::SEED_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/prc_gen.sv @@
// Generator register: value*75 folded modulo 65537, one step per accepted beat.
`default_nettype none
module prc_gen (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic                      restart,
  input  wire logic [prc_pkg::SEED_W-1:0] seed,
  output logic      [prc_pkg::SEED_W-1:0] value
);
  import prc_pkg::*;

  logic [SEED_W-1:0] base;
  logic [PROD_W-1:0] prod;
  logic [15:0]       lo;
  logic [7:0]        hi;
  logic [SEED_W-1:0] value_next;

  assign base = restart ? seed : value;
  assign prod = PROD_W'(base) * PROD_W'(GEN_MULT);
  assign lo   = prod[15:0];
  assign hi   = prod[PROD_W-1:16];

  // the intermediate stays within 17 bits; the folded result always fits
  always_comb begin
    if (lo >= 16'(hi)) begin
      value_next = SEED_W'(lo) - SEED_W'(hi);
    end else begin
      value_next = SEED_W'(lo) + GEN_MOD - SEED_W'(hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= GEN_RESET;
    end else if (step) begin
      value <= value_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/prc_rot.sv @@
// Rotation of printable codes 32..127 by the generator value modulo 96.
`default_nettype none
module prc_rot (
  input  wire logic [prc_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [prc_pkg::SEED_W-1:0] value,
  input  wire logic                       backward,
  output logic      [prc_pkg::BYTE_W-1:0] out_byte
);
  import prc_pkg::*;

  logic [11:0]         upper;
  logic [27:0]         quot_prod;
  logic [10:0]         quot;
  logic [11:0]         rem3;
  logic [AMOUNT_W-1:0] amount;
  logic [AMOUNT_W-1:0] off;
  logic [BYTE_W-1:0]   sum;
  logic [BYTE_W-1:0]   wrapped;
  logic                printable;

  // value mod 96 = 32 * ((value >> 5) mod 3) + (value mod 32)
  assign upper     = value[SEED_W-1:5];
  assign quot_prod = 28'(upper) * 28'(DIV3_RECIP);
  assign quot      = quot_prod[DIV3_SHIFT +: 11];
  assign rem3      = upper - 12'(quot) * 12'd3;
  assign amount    = {rem3[1:0], value[4:0]};

  assign printable = (data_byte >= CODE_LOW) && !data_byte[BYTE_W-1];
  assign off       = AMOUNT_W'(data_byte - CODE_LOW);

  always_comb begin
    if (backward) begin
      sum = BYTE_W'(off) + CODE_SPAN - BYTE_W'(amount);
    end else begin
      sum = BYTE_W'(off) + BYTE_W'(amount);
    end
    wrapped  = (sum >= CODE_SPAN) ? sum - CODE_SPAN : sum;
    out_byte = printable ? wrapped + CODE_LOW : data_byte;
  end

endmodule
`default_nettype wire

@@ sv/prng_rotation_stream_cipher.sv @@
// Top level: configuration registers, input stage, rotation and output register.
//
//   port  | kind   | payload
//   ------+--------+-------------------------------
//   src   | sink   | data_byte[7:0], restart
//   dst   | source | out_byte[7:0]
//   cfg   | sink   | index[1:0], data[16:0]
//
// One byte per cycle sustained while the output is ready. The generator
// register steps in the cycle of the input beat; the byte waits in the input
// stage and is rotated into the output register when the output advances.
// A stalled output holds both stages; src.ready drops only when both are full.
// Reset: generator 1, decrypt_mode 0, start_seed 1, both stages empty.
`default_nettype none
module prng_rotation_stream_cipher (
  input  wire logic clk,
  input  wire logic rst,
  prc_in_if.sink    src,
  prc_out_if.source dst,
  prc_cfg_if.sink   cfg
);
  import prc_pkg::*;

  logic              decrypt_mode;
  logic [SEED_W-1:0] start_seed;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [SEED_W-1:0] gen_value;
  logic [BYTE_W-1:0] rot_byte;
  logic              advance;
  logic              take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      start_seed   <= GEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DECRYPT_MODE: decrypt_mode <= cfg.data[0];
        REG_START_SEED:   start_seed   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid || dst.ready;
  assign src.ready = !s1_valid || advance;
  assign take      = src.valid && src.ready;

  prc_gen u_gen (
    .clk     (clk),
    .rst     (rst),
    .step    (take),
    .restart (src.restart),
    .seed    (start_seed),
    .value   (gen_value)
  );

  // gen_value belongs to the byte in s1 until the next beat is taken
  prc_rot u_rot (
    .data_byte (s1_byte),
    .value     (gen_value),
    .backward  (decrypt_mode),
    .out_byte  (rot_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_byte <= src.data_byte;
    end
    if (advance && s1_valid) begin
      out_byte <= rot_byte;
    end
  end

  assign dst.valid    = out_valid;
  assign dst.out_byte = out_byte;

endmodule
`default_nettype wire

@@ sv/prc_chk.sv @@
// Port checker for the cipher top level, attached by bind.
`default_nettype none
module prc_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic src_valid,
  input wire logic src_ready,
  input wire logic dst_valid,
  input wire logic dst_ready,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid)
    else $error("output beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !dst_valid |-> src_ready)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_ready |=> ##1 dst_valid)
    else $error("accepted byte did not reach the output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind prng_rotation_stream_cipher prc_chk u_prc_chk (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src.valid),
  .src_ready (src.ready),
  .dst_valid (dst.valid),
  .dst_ready (dst.ready),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready)
);
`default_nettype wire

@@ verif/prc_cipher_checker.sv @@
`timescale 1ns / 100ps
// Cipher checker: tracks the generator and settings, predicts each output byte and compares.
module prc_cipher_checker (
  input  logic clk,
  input  logic rst,
  prc_in_if    in_ch,
  prc_out_if   out_ch,
  prc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import prc_pkg::*;

  logic              decrypt_q;
  logic [SEED_W-1:0] seed_q;
  logic [SEED_W-1:0] lehmer_q;
  logic [BYTE_W-1:0] expected_cipher_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // One step of value*75 mod 65537, folded as low half minus high part.
  function automatic logic [SEED_W-1:0] lehmer_next(input logic [SEED_W-1:0] v);
    int prod;
    int lo;
    int hi;
    prod = int'(v) * int'(GEN_MULT);
    lo   = prod & 16'hFFFF;
    hi   = prod >>> 16;
    if (lo >= hi) begin
      return SEED_W'(lo - hi);
    end
    return SEED_W'(lo + int'(GEN_MOD) - hi);
  endfunction

  function automatic logic [BYTE_W-1:0] rotate_printable(input logic [BYTE_W-1:0] b,
                                                         input logic [SEED_W-1:0] g,
                                                         input logic backward);
    int span;
    int off;
    int amt;
    span = int'(CODE_SPAN);
    if (int'(b) < int'(CODE_LOW) || int'(b) >= int'(CODE_LOW) + span) begin
      return b;
    end
    off = int'(b) - int'(CODE_LOW);
    amt = int'(g) % span;
    if (backward) begin
      off = (off + span - amt) % span;
    end else begin
      off = (off + amt) % span;
    end
    return BYTE_W'(off + int'(CODE_LOW));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : track_beats
    logic [BYTE_W-1:0] want;
    if (rst) begin
      decrypt_q = 1'b0;
      seed_q    = GEN_RESET;
      lehmer_q  = GEN_RESET;
      expected_cipher_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        // indexes past the seed register are dropped by the block
        if (cfg_ch.index == REG_DECRYPT_MODE) begin
          decrypt_q = cfg_ch.data[0];
        end else if (cfg_ch.index == REG_START_SEED) begin
          seed_q = cfg_ch.data;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.restart) begin
          lehmer_q = seed_q;
        end
        lehmer_q = lehmer_next(lehmer_q);
        expected_cipher_q.push_back(rotate_printable(in_ch.data_byte, lehmer_q, decrypt_q));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cipher_q.size() == 0) begin
          report_mismatch($sformatf("out_byte %02h with no byte pending", out_ch.out_byte));
        end else begin
          want = expected_cipher_q.pop_front();
          if (out_ch.out_byte !== want) begin
            report_mismatch($sformatf("out_byte %02h, predicted %02h", out_ch.out_byte, want));
          end
        end
      end
    end
    // publish after the edge so the stimulus side samples a settled count
    pending <= expected_cipher_q.size();
  end

endmodule

@@ verif/prng_rotation_stream_cipher_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, byte and register stimulus, output back-pressure and verdict.
module prng_rotation_stream_cipher_tb;
  import prc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 64;
  localparam int IDLE_PCT      = 18;
  localparam int RESTART_PCT   = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES   = 170;
  localparam int DRAIN_TAIL    = 6;
  localparam int BURST_PHASE   = 2;
  localparam int SPARE_PHASE   = 3;
  localparam int HOLD_PHASE    = 4;
  localparam int PAUSE_PHASE   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [SEED_W-1:0]    SEED_ZERO    = '0;
  localparam logic [SEED_W-1:0]    SEED_TOP     = 17'd65536;
  localparam logic [SEED_W-1:0]    SEED_MAX     = '1;
  localparam logic [BYTE_W-1:0]    BYTE_MAX     = '1;
  localparam int PRINT_LO = int'(CODE_LOW);
  localparam int PRINT_HI = int'(CODE_LOW) + int'(CODE_SPAN) - 1;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_cnt;
  int   bytes_sent;
  int   restarts_sent;
  int   settings_done;
  bit   burst;
  bit   stall_request;

  prc_in_if  in_ch();
  prc_out_if out_ch();
  prc_cfg_if cfg_ch();

  prng_rotation_stream_cipher u_dut (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch),
    .cfg (cfg_ch)
  );

  prc_cipher_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic restart);
    if (!burst) begin
      while ($urandom_range(99, 0) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart   <= restart;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (restart) begin
      restarts_sent++;
    end
  endtask

  // Hold the input and wait for every predicted byte to come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(input logic mode, input logic [SEED_W-1:0] seed,
                              input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [SEED_W-1:0]    val[3];
    int                   n;
    idx[0] = REG_DECRYPT_MODE;
    val[0] = SEED_W'($urandom);
    val[0][0] = mode;
    idx[1] = REG_START_SEED;
    val[1] = seed;
    idx[2] = CFG_IDX_W'($urandom_range(int'(REG_SPARE_HI), int'(REG_SPARE_LO)));
    val[2] = SEED_W'($urandom);
    n = poke_spare ? 3 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    settings_done++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 60) begin
      return BYTE_W'($urandom_range(PRINT_HI, PRINT_LO));
    end else if (sel < 80) begin
      return BYTE_W'($urandom_range(int'(BYTE_MAX), PRINT_HI + 1));
    end else if (sel < 90) begin
      return BYTE_W'($urandom_range(PRINT_LO - 1, 0));
    end
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [SEED_W-1:0] seed_for_phase(input int p);
    case (p)
      0: return SEED_TOP;
      1: return GEN_RESET;
      2: return SEED_MAX;
      3: return SEED_TOP + 1'b1;
      default: begin
        if (p % 2 == 1) begin
          return SEED_W'($urandom_range(int'(SEED_TOP), 1));
        end
        return SEED_W'($urandom);
      end
    endcase
  endfunction

  initial begin : out_sink
    int held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        out_ch.ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) begin
          stall_request = 1'b0;
          held = 0;
        end
      end else if (burst) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) begin
      @(posedge clk);
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    burst         = 1'b0;
    stall_request = 1'b0;
    bytes_sent    = 0;
    restarts_sent = 0;
    settings_done = 0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.restart   <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_DECRYPT_MODE;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: encrypt, generator at one, code range edges
    send_byte(8'd65, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(CODE_LOW - 1'b1, 1'b0);
    send_byte(CODE_LOW, 1'b0);
    send_byte(8'd127, 1'b0);
    send_byte(8'd128, 1'b0);
    send_byte(BYTE_MAX, 1'b0);
    send_byte(8'd126, 1'b1);

    // zero seed parks the generator, so every byte passes through
    wait_idle();
    program_regs(1'b1, SEED_ZERO, 1'b1);
    send_byte(8'd80, 1'b1);
    send_byte(CODE_LOW, 1'b0);
    send_byte(8'd127, 1'b0);
    send_byte(8'd200, 1'b0);

    // seeds above the modulus fold back on the first step
    wait_idle();
    program_regs(1'b1, SEED_MAX, 1'b0);
    send_byte(8'd65, 1'b1);
    send_byte(8'd127, 1'b0);
    send_byte(CODE_LOW, 1'b0);
    send_byte(8'd95, 1'b0);

    wait_idle();
    program_regs(1'b0, SEED_TOP, 1'b1);
    send_byte(8'd127, 1'b1);
    send_byte(CODE_LOW, 1'b0);
    send_byte(8'd96, 1'b0);

    wait_idle();
    program_regs(1'b0, SEED_TOP + 1'b1, 1'b0);
    send_byte(8'd100, 1'b1);
    send_byte(8'd50, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      program_regs(p[0], seed_for_phase(p), p == SPARE_PHASE);
      burst = (p == BURST_PHASE);
      if (p == HOLD_PHASE) begin
        stall_request = 1'b1;
      end
      for (int k = 0; k < PHASE_BYTES; k++) begin
        if (p == PAUSE_PHASE && k == PHASE_BYTES / 2) begin
          wait_idle();
        end
        send_byte(pick_byte(), k == 0 || $urandom_range(99, 0) < RESTART_PCT);
      end
    end
    burst = 1'b0;

    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Run sent %0d bytes, %0d of them with restart, under %0d register settings.",
             bytes_sent, restarts_sent, settings_done);
    $display("Both directions, seeds from zero to the 17-bit maximum, one long output stall.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
